FILE: design/hfsa_pkg.sv
// shared types and constants of the highest-fit segment allocator
package hfsa_pkg;

	localparam int DATA_W = 16;
	localparam int TAG_W = 8;
	localparam int STAT_W = 3;
	localparam int MAX_SEGMENTS_DEF = 16;
	localparam logic [DATA_W-1:0] TOTAL_RESET = 16'd1024;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 3'd0,
		STAT_EXCEEDS  = 3'd1,
		STAT_NOFIT    = 3'd2,
		STAT_NOTFOUND = 3'd3,
		STAT_FULL     = 3'd4
	} status_t;

	typedef enum logic {
		FSM_IDLE  = 1'b0,
		FSM_APPLY = 1'b1
	} state_t;

	typedef enum logic [1:0] {
		CMD_HOLD    = 2'd0,
		CMD_LOAD    = 2'd1,
		CMD_FROM_LO = 2'd2,
		CMD_FROM_HI = 2'd3
	} cell_cmd_t;

	typedef struct packed {
		logic [DATA_W-1:0] start;
		logic [DATA_W-1:0] len;
		logic [TAG_W-1:0]  tag;
	} seg_t;

endpackage

FILE: design/highest_fit_segment_allocator.sv
// top level of the highest-fit segment allocator
// the accepting edge enters the apply state, whose busy cycle registers the result and its strobe; busy for one cycle
// a new item is accepted only while idle, not in the busy cycle; gap checks run in every cell in the accept cycle
// the pick and the one-step row shift run in the single busy cycle
// reset: table empty, total and free units 1024; results cannot be stalled
module highest_fit_segment_allocator #(
	parameter int MAX_SEGMENTS = hfsa_pkg::MAX_SEGMENTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [hfsa_pkg::DATA_W-1:0]      cfg_wr_data,
	input  logic                             start,
	output logic                             busy,
	input  logic                             op,
	input  logic [hfsa_pkg::TAG_W-1:0]       tag,
	input  logic [hfsa_pkg::DATA_W-1:0]      req_size,
	output logic                             done,
	output logic [hfsa_pkg::STAT_W-1:0]      status,
	output logic [hfsa_pkg::DATA_W-1:0]      start_addr,
	output logic [hfsa_pkg::DATA_W-1:0]      free_after
);
	import hfsa_pkg::*;

	localparam int N = MAX_SEGMENTS;
	localparam int CW = $clog2(N+1);

	state_t            state_q;
	state_t            state_d;
	logic [DATA_W-1:0] total_q;
	logic [DATA_W-1:0] free_q;
	logic [CW-1:0]     count_q;
	op_t               op_q;
	logic [TAG_W-1:0]  tag_q;
	logic [DATA_W-1:0] size_q;
	logic              done_q;
	status_t           status_q;
	logic [DATA_W-1:0] addr_q;
	logic [DATA_W-1:0] free_after_q;

	logic              accept;
	logic              apply;
	status_t           stat_d;
	logic              ok;

	seg_t              segs [N];
	cell_cmd_t         cmds [N];
	logic [N-1:0][DATA_W:0]   ends;
	logic [N-1:0]             fits;
	logic [N-1:0]             tag_hits;
	logic [N-1:0][DATA_W-1:0] cands;
	logic              any_fit;
	logic              any_match;
	logic [DATA_W-1:0] sel_cand;
	logic [DATA_W-1:0] sel_start;
	logic [DATA_W-1:0] sel_len;
	seg_t              new_seg;

	assign accept = start && (state_q == FSM_IDLE);
	assign new_seg = '{start: sel_cand, len: size_q, tag: tag_q};

	always_comb begin
		unique case (state_q)
			FSM_IDLE:  state_d = accept ? FSM_APPLY : FSM_IDLE;
			FSM_APPLY: state_d = FSM_IDLE;
			default:   state_d = FSM_IDLE;
		endcase
	end

	always_comb begin
		unique case (state_q)
			FSM_IDLE: begin
				busy = 1'b0;
				apply = 1'b0;
			end
			FSM_APPLY: begin
				busy = 1'b1;
				apply = 1'b1;
			end
			default: begin
				busy = 1'b0;
				apply = 1'b0;
			end
		endcase
	end

	always_comb begin
		if (op_q == OP_ALLOC) begin
			if (size_q > free_q) begin
				stat_d = STAT_EXCEEDS;
			end else if (count_q >= CW'(N)) begin
				stat_d = STAT_FULL;
			end else if (!any_fit) begin
				stat_d = STAT_NOFIT;
			end else begin
				stat_d = STAT_OK;
			end
		end else begin
			stat_d = any_match ? STAT_OK : STAT_NOTFOUND;
		end
		ok = apply && (stat_d == STAT_OK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			total_q <= TOTAL_RESET;
			free_q <= TOTAL_RESET;
			count_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= apply;
			if (cfg_wr_en) begin
				total_q <= cfg_wr_data;
				free_q <= cfg_wr_data;
				count_q <= '0;
			end else if (ok) begin
				if (op_q == OP_ALLOC) begin
					free_q <= free_q - size_q;
					count_q <= count_q + CW'(1);
				end else begin
					free_q <= free_q + sel_len;
					count_q <= count_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op_t'(op);
			tag_q <= tag;
			size_q <= req_size;
		end
		if (apply) begin
			status_q <= stat_d;
			if (stat_d != STAT_OK) begin
				addr_q <= '0;
				free_after_q <= free_q;
			end else if (op_q == OP_ALLOC) begin
				addr_q <= sel_cand;
				free_after_q <= free_q - size_q;
			end else begin
				addr_q <= sel_start;
				free_after_q <= free_q + sel_len;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		hfsa_cell #(
			.N   (N),
			.IDX (i)
		) u_cell (
			.clk        (clk),
			.capture    (accept),
			.count      (count_q),
			.total_size (total_q),
			.req_size   (req_size),
			.req_tag    (tag),
			.lo_end     ((i == 0) ? '0 : ends[(i == 0) ? 0 : i-1]),
			.lower_seg  (segs[(i == 0) ? 0 : i-1]),
			.upper_seg  (segs[(i == N-1) ? N-1 : i+1]),
			.new_seg    (new_seg),
			.cmd        (cmds[i]),
			.seg        (segs[i]),
			.end_sum    (ends[i]),
			.fit        (fits[i]),
			.match      (tag_hits[i]),
			.cand       (cands[i])
		);
	end

	hfsa_pick #(
		.N (N)
	) u_pick (
		.enable    (ok),
		.op        (op_q),
		.fit       (fits),
		.match     (tag_hits),
		.cand      (cands),
		.segs      (segs),
		.cmd       (cmds),
		.any_fit   (any_fit),
		.any_match (any_match),
		.sel_cand  (sel_cand),
		.sel_start (sel_start),
		.sel_len   (sel_len)
	);

	assign done = done_q;
	assign status = status_q;
	assign start_addr = addr_q;
	assign free_after = free_after_q;

endmodule

FILE: design/hfsa_cell.sv
// one table entry with its gap check and neighbor shift
module hfsa_cell #(
	parameter int N   = hfsa_pkg::MAX_SEGMENTS_DEF,
	parameter int IDX = 0
) (
	input  logic                             clk,
	input  logic                             capture,
	input  logic [$clog2(N+1)-1:0]           count,
	input  logic [hfsa_pkg::DATA_W-1:0]      total_size,
	input  logic [hfsa_pkg::DATA_W-1:0]      req_size,
	input  logic [hfsa_pkg::TAG_W-1:0]       req_tag,
	input  logic [hfsa_pkg::DATA_W:0]        lo_end,
	input  hfsa_pkg::seg_t                   lower_seg,
	input  hfsa_pkg::seg_t                   upper_seg,
	input  hfsa_pkg::seg_t                   new_seg,
	input  hfsa_pkg::cell_cmd_t              cmd,
	output hfsa_pkg::seg_t                   seg,
	output logic [hfsa_pkg::DATA_W:0]        end_sum,
	output logic                             fit,
	output logic                             match,
	output logic [hfsa_pkg::DATA_W-1:0]      cand
);
	import hfsa_pkg::*;

	localparam int CW = $clog2(N+1);

	seg_t              seg_q;
	logic              fit_q;
	logic              match_q;
	logic [DATA_W-1:0] cand_q;
	logic [DATA_W-1:0] hi;
	logic [DATA_W+1:0] diff;
	logic [DATA_W:0]   gap;
	logic              fit_d;
	logic              match_d;

	always_comb begin
		hi = (count == CW'(IDX)) ? total_size : seg_q.start;
		diff = {2'b00, hi} - {1'b0, lo_end};
		gap = diff[DATA_W+1] ? '0 : diff[DATA_W:0];
		fit_d = (count >= CW'(IDX)) && (gap >= {1'b0, req_size});
		match_d = (count > CW'(IDX)) && (seg_q.tag == req_tag);
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			fit_q <= fit_d;
			match_q <= match_d;
			cand_q <= hi - req_size;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD:    seg_q <= new_seg;
			CMD_FROM_LO: seg_q <= lower_seg;
			CMD_FROM_HI: seg_q <= upper_seg;
			default:     seg_q <= seg_q;
		endcase
	end

	assign seg = seg_q;
	assign end_sum = {1'b0, seg_q.start} + {1'b0, seg_q.len};
	assign fit = fit_q;
	assign match = match_q;
	assign cand = cand_q;

endmodule

FILE: design/hfsa_pick.sv
// priority pick of the target cell and shift commands for the row
module hfsa_pick #(
	parameter int N = hfsa_pkg::MAX_SEGMENTS_DEF
) (
	input  logic                             enable,
	input  hfsa_pkg::op_t                    op,
	input  logic [N-1:0]                     fit,
	input  logic [N-1:0]                     match,
	input  logic [N-1:0][hfsa_pkg::DATA_W-1:0] cand,
	input  hfsa_pkg::seg_t                   segs [N],
	output hfsa_pkg::cell_cmd_t              cmd [N],
	output logic                             any_fit,
	output logic                             any_match,
	output logic [hfsa_pkg::DATA_W-1:0]      sel_cand,
	output logic [hfsa_pkg::DATA_W-1:0]      sel_start,
	output logic [hfsa_pkg::DATA_W-1:0]      sel_len
);
	import hfsa_pkg::*;

	logic [N-1:0] fit_rev;
	logic [N-1:0] top_rev;
	logic [N-1:0] top_fit;
	logic [N-1:0] low_match;
	logic [N-1:0] pick;
	logic [N-1:0] above;

	always_comb begin
		for (int i = 0; i < N; i++) begin
			fit_rev[i] = fit[N-1-i];
		end
		top_rev = fit_rev & (~fit_rev + N'(1));
		for (int i = 0; i < N; i++) begin
			top_fit[i] = top_rev[N-1-i];
		end
		low_match = match & (~match + N'(1));
		pick = (op == OP_ALLOC) ? top_fit : low_match;
		above = ~(pick | (pick - N'(1)));
	end

	assign any_fit = |fit;
	assign any_match = |match;

	always_comb begin
		sel_cand = '0;
		sel_start = '0;
		sel_len = '0;
		for (int i = 0; i < N; i++) begin
			if (pick[i]) begin
				sel_cand = sel_cand | cand[i];
				sel_start = sel_start | segs[i].start;
				sel_len = sel_len | segs[i].len;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < N; i++) begin
			cmd[i] = CMD_HOLD;
			if (enable) begin
				if (op == OP_ALLOC) begin
					if (pick[i]) begin
						cmd[i] = CMD_LOAD;
					end else if (above[i]) begin
						cmd[i] = CMD_FROM_LO;
					end
				end else if (pick[i] || above[i]) begin
					cmd[i] = CMD_FROM_HI;
				end
			end
		end
	end

endmodule

FILE: design/hfsa_chk.sv
// port-level checker of the allocator and its binding
module hfsa_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic [hfsa_pkg::STAT_W-1:0] status,
	input logic [hfsa_pkg::DATA_W-1:0] start_addr
);
	import hfsa_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (done && !busy))
		else $error("busy cycle not followed by a result");

	a_done_only_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy) |=> !done)
		else $error("result without a busy cycle");

	a_error_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != STAT_OK)) |-> (start_addr == '0))
		else $error("nonzero start address on error");

endmodule

bind highest_fit_segment_allocator hfsa_chk u_hfsa_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.status     (status),
	.start_addr (start_addr)
);
